### hw/rtl/fms_pkg.sv
package fms_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_TICK        = 2'd0;
    localparam logic [1:0] REQ_CALIBRATE   = 2'd1;
    localparam logic [1:0] REQ_MOVE        = 2'd2;
    localparam logic [1:0] REQ_MOVE_NOPICK = 2'd3;

    // Rack motor commands.
    localparam logic [1:0] RACK_NONE = 2'd0;
    localparam logic [1:0] RACK_CAL  = 2'd1;
    localparam logic [1:0] RACK_UP   = 2'd2;
    localparam logic [1:0] RACK_DOWN = 2'd3;

    // Slider commands.
    localparam logic [1:0] SLIDER_NONE = 2'd0;
    localparam logic [1:0] SLIDER_CAL  = 2'd1;
    localparam logic [1:0] SLIDER_MOVE = 2'd2;

    // Fingering commands.
    localparam logic [1:0] FINGER_NONE = 2'd0;
    localparam logic [1:0] FINGER_CAL  = 2'd1;
    localparam logic [1:0] FINGER_PUSH = 2'd2;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE            = 4'd0;
    localparam logic [3:0] PH_CAL_RACK        = 4'd1;
    localparam logic [3:0] PH_CAL_WAIT_RACK   = 4'd2;
    localparam logic [3:0] PH_CAL_SLIDER      = 4'd3;
    localparam logic [3:0] PH_CAL_WAIT_SLIDER = 4'd4;
    localparam logic [3:0] PH_CAL_FINGER      = 4'd5;
    localparam logic [3:0] PH_UP              = 4'd6;
    localparam logic [3:0] PH_WAIT_UP         = 4'd7;
    localparam logic [3:0] PH_SLIDE           = 4'd8;
    localparam logic [3:0] PH_WAIT_SLIDE      = 4'd9;
    localparam logic [3:0] PH_DOWN            = 4'd10;
    localparam logic [3:0] PH_WAIT_DOWN       = 4'd11;
    localparam logic [3:0] PH_PRESS           = 4'd12;

    // A pending distance of -1 is sent to the slider as 0.
    localparam logic [9:0] DIST_MINUS_ONE = 10'h3FF;

    localparam logic [31:0] WAIT_DELAY_RESET = 32'd100000;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [9:0] distance_mm;
        logic [31:0]       now_us;
        logic              rack_done;
        logic              slider_done;
        logic              fingering_done;
    } t_item;

    typedef struct packed {
        logic [1:0]        rack_cmd;
        logic [1:0]        slider_cmd;
        logic signed [9:0] slider_target;
        logic [1:0]        fingering_cmd;
        logic [3:0]        phase;
        logic              all_complete;
    } t_result;

endpackage

### hw/rtl/fms_seq.sv
module fms_seq
    import fms_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic [31:0] i_wait_delay,
    output t_result     o_result
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [3:0]           r_phase, n_phase;
    logic [TIME_BITS-1:0] r_wait_start, n_wait_start;
    logic [9:0]           r_pending, n_pending;
    logic                 r_skip, n_skip;

    logic [CMP_W-1:0]     w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_wait_over;

    // Elapsed time since the wait began, wrapping in the time width.
    assign w_now_ext   = CMP_W'(i_item.now_us);
    assign w_now       = w_now_ext[TIME_BITS-1:0];
    assign w_diff      = w_now - r_wait_start;
    assign w_wait_over = CMP_W'(w_diff) >= CMP_W'(i_wait_delay);

    // Next state and commands for the word in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_wait_start = r_wait_start;
        n_pending    = r_pending;
        n_skip       = r_skip;
        o_result     = '0;

        if (i_item.req_type == REQ_CALIBRATE) begin
            n_phase           = PH_CAL_RACK;
            o_result.rack_cmd = RACK_CAL;
        end else if (i_item.req_type inside {REQ_MOVE, REQ_MOVE_NOPICK}) begin
            // The no-pluck flag sticks even when the move is refused.
            if (i_item.req_type == REQ_MOVE_NOPICK) begin
                n_skip = 1'b1;
            end
            if (r_phase == PH_IDLE) begin
                n_pending         = i_item.distance_mm;
                o_result.rack_cmd = RACK_UP;
                n_phase           = PH_UP;
            end
        end else begin
            case (r_phase)
                PH_CAL_RACK: begin
                    if (i_item.rack_done) begin
                        n_wait_start = w_now;
                        n_phase      = PH_CAL_WAIT_RACK;
                    end
                end
                PH_CAL_WAIT_RACK: begin
                    if (w_wait_over) begin
                        n_phase             = PH_CAL_SLIDER;
                        o_result.slider_cmd = SLIDER_CAL;
                    end
                end
                PH_CAL_SLIDER: begin
                    if (i_item.slider_done) begin
                        n_wait_start = w_now;
                        n_phase      = PH_CAL_WAIT_SLIDER;
                    end
                end
                PH_CAL_WAIT_SLIDER: begin
                    if (w_wait_over) begin
                        n_phase                = PH_CAL_FINGER;
                        o_result.fingering_cmd = FINGER_CAL;
                    end
                end
                PH_CAL_FINGER: begin
                    if (i_item.fingering_done) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_UP: begin
                    if (i_item.rack_done) begin
                        n_wait_start = w_now;
                        n_phase      = PH_WAIT_UP;
                    end
                end
                PH_WAIT_UP: begin
                    if (w_wait_over) begin
                        o_result.slider_cmd    = SLIDER_MOVE;
                        o_result.slider_target = (r_pending == DIST_MINUS_ONE) ?
                                                 10'sd0 : $signed(r_pending);
                        n_phase                = PH_SLIDE;
                    end
                end
                PH_SLIDE: begin
                    if (i_item.slider_done) begin
                        n_wait_start = w_now;
                        n_phase      = PH_WAIT_SLIDE;
                    end
                end
                PH_WAIT_SLIDE: begin
                    // A negative distance presses straight after the slide.
                    if (w_wait_over) begin
                        if (r_pending[9]) begin
                            o_result.fingering_cmd = FINGER_PUSH;
                            n_phase                = PH_PRESS;
                        end else begin
                            o_result.rack_cmd = RACK_DOWN;
                            n_phase           = PH_DOWN;
                        end
                    end
                end
                PH_DOWN: begin
                    if (i_item.rack_done) begin
                        n_wait_start = w_now;
                        n_phase      = PH_WAIT_DOWN;
                    end
                end
                PH_WAIT_DOWN: begin
                    if (w_wait_over) begin
                        if (r_skip) begin
                            n_skip  = 1'b0;
                            n_phase = PH_IDLE;
                        end else begin
                            o_result.fingering_cmd = FINGER_PUSH;
                            n_phase                = PH_PRESS;
                        end
                    end
                end
                PH_PRESS: begin
                    if (i_item.fingering_done) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        o_result.phase        = n_phase;
        o_result.all_complete = (n_phase == PH_IDLE) && i_item.rack_done &&
                                i_item.slider_done && i_item.fingering_done;
    end

    // Sequencer state advances only when the word moves to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait_start <= '0;
            r_pending    <= '0;
            r_skip       <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_wait_start <= n_wait_start;
            r_pending    <= n_pending;
            r_skip       <= n_skip;
        end
    end

endmodule

### hw/rtl/finger_motion_sequencer.sv
// Motion sequencer for the rack, slider and fingering actuators.
// Input stream: one word per event. s_axis_tuser is the request kind
// (tick, calibrate, move, move without pluck); s_axis_tdata carries the
// target distance, the microsecond time and the three motor done flags.
// Output stream: one word per input word, with the motor commands, the
// phase after the event and the all-complete status.
// The settle delay is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while the stream is idle (the block does not enforce
// this). It resets to 100000 us. An accepted word passes through the input
// register and then the output register before it is valid on the output.
// The state machine and the one wrapping subtract-and-compare run on the
// input register. Throughput is one word per cycle while the receiver does
// not stall; the input register and the output register form a two-stage pipeline.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; s_axis_tready falls only when both are full.
// Reset (synchronous, active low) returns the sequencer to idle, clears
// the pending distance and the no-pluck flag and empties both registers.
module finger_motion_sequencer
    import fms_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] distance_mm, [41:10] now_us, [42] rack_done, [43] slider_done,
    // [44] fingering_done, [47:45] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] rack_cmd, [3:2] slider_cmd, [13:4] slider_target,
    // [15:14] fingering_cmd, [19:16] phase, [20] all_complete, [23:21] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [31:0]           i_cfg_wr_data
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_wait_delay;

    logic        w_advance;
    t_result     w_result;

    // The pipeline moves when the output slot is free or being taken.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Settle delay register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_delay <= WAIT_DELAY_RESET;
        end else if (i_cfg_wr_en) begin
            r_wait_delay <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type       <= s_axis_tuser;
            r_in.distance_mm    <= $signed(s_axis_tdata[9:0]);
            r_in.now_us         <= s_axis_tdata[41:10];
            r_in.rack_done      <= s_axis_tdata[42];
            r_in.slider_done    <= s_axis_tdata[43];
            r_in.fingering_done <= s_axis_tdata[44];
        end
    end

    fms_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (r_in_valid && w_advance),
        .i_item       (r_in),
        .i_wait_delay (r_wait_delay),
        .o_result     (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.all_complete, r_out.phase, r_out.fingering_cmd,
                            r_out.slider_target, r_out.slider_cmd, r_out.rack_cmd};

endmodule

### hw/rtl/fms_checker.sv
module fms_checker
    import fms_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Back pressure reaches the input only when the output is stalled.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // An accepted word reaches the output once the receiver is ready.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted word did not reach the output");

    // A calibrate command always leaves the sequencer in the rack calibration phase.
    a_cal_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == RACK_CAL) |->
            m_axis_tdata[19:16] == PH_CAL_RACK)
        else $error("calibrate command with wrong phase");

    // Completion is only reported from idle.
    a_complete_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:16] == PH_IDLE)
        else $error("all_complete outside idle");

endmodule

bind finger_motion_sequencer fms_checker u_fms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
